// ----- hdl/alarm_clock_with_dawn_ramp_core_defines.svh -----
// ----------------------------------------------------------------------------
// Alarm clock with dawn ramp: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALARM_CLOCK_WITH_DAWN_RAMP_CORE_DEFINES_SVH
`define ALARM_CLOCK_WITH_DAWN_RAMP_CORE_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define ACWDR_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("acwdr: invariant violated");

// When the antecedent holds, the consequent must hold in the next clock cycle.
`define ACWDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acwdr: next-cycle check failed");

`endif

// ----- hdl/acwdr_pkg.sv -----
// ----------------------------------------------------------------------------
// Alarm clock with dawn ramp: package
// Transaction types, codes, limits and field helper functions.
// ----------------------------------------------------------------------------
package acwdr_pkg;

    // Item kinds.
    localparam logic [2:0] MODE_INIT        = 3'd0;
    localparam logic [2:0] MODE_MINUTE_TICK = 3'd1;
    localparam logic [2:0] MODE_RAMP_TICK   = 3'd2;
    localparam logic [2:0] MODE_SET_EVENT   = 3'd3;
    localparam logic [2:0] MODE_RUN_EVENT   = 3'd4;

    // Encoder codes.
    localparam logic [2:0] ENC_PRESS    = 3'd1;
    localparam logic [2:0] ENC_DOWN     = 3'd2;
    localparam logic [2:0] ENC_UP       = 3'd3;
    localparam logic [2:0] ENC_DOWN_TEN = 3'd5;
    localparam logic [2:0] ENC_UP_TEN   = 3'd6;

    // Commit requests.
    localparam logic [1:0] COMMIT_NONE  = 2'd0;
    localparam logic [1:0] COMMIT_CLOCK = 2'd1;
    localparam logic [1:0] COMMIT_ALARM = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 6;
    localparam logic [CFG_INDEX_W-1:0] REG_STORED_ALARM_HOUR   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STORED_ALARM_MINUTE = 1'd1;

    // Field limits.
    localparam logic [5:0] HOUR_MAX            = 6'd23;
    localparam logic [5:0] MINUTE_MAX          = 6'd59;
    localparam logic [5:0] HOUR_UP_TEN_LIMIT   = 6'd14;
    localparam logic [5:0] MINUTE_UP_TEN_LIMIT = 6'd50;
    localparam logic [5:0] STEP_TEN            = 6'd10;
    localparam logic [7:0] MAX_BRIGHTNESS      = 8'd255;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] enc_code;
        logic       edit_alarm;
        logic [4:0] rtc_hour;
        logic [5:0] rtc_minute;
    } item_t;

    typedef struct packed {
        logic [4:0] clock_hour;
        logic [5:0] clock_minute;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       editing_minute;
        logic       alarm_on;
        logic       lamp_lit;
        logic [7:0] brightness;
        logic [1:0] commit;
    } result_t;

    // Out-of-range hours load as zero.
    function automatic logic [4:0] load_hour(input logic [4:0] value);
        return ({1'b0, value} > HOUR_MAX) ? 5'd0 : value;
    endfunction

    // Out-of-range minutes load as zero.
    function automatic logic [5:0] load_minute(input logic [5:0] value);
        return (value > MINUTE_MAX) ? 6'd0 : value;
    endfunction

    // True when a widened minute count is a multiple of ten.
    function automatic logic is_multiple_of_ten(input logic [6:0] value);
        logic hit;
        case (value)
            7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60,
            7'd70, 7'd80, 7'd90, 7'd100, 7'd110, 7'd120: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // One encoder step on a field: wrap on single steps, bounds on tens.
    function automatic logic [5:0] step_field(input logic [2:0] code,
                                              input logic [5:0] value,
                                              input logic [5:0] top,
                                              input logic [5:0] up_limit);
        logic [5:0] result;
        result = value;
        case (code)
            ENC_DOWN:     result = (value != 6'd0 && value <= top) ? value - 6'd1 : top;
            ENC_UP:       result = (value < top) ? value + 6'd1 : 6'd0;
            ENC_DOWN_TEN: result = (value >= STEP_TEN) ? value - STEP_TEN : value;
            ENC_UP_TEN:   result = (value < up_limit) ? value + STEP_TEN : value;
            default:      result = value;
        endcase
        return result;
    endfunction

endpackage

// ----- hdl/alarm_clock_with_dawn_ramp_core.sv -----
// ----------------------------------------------------------------------------
// Alarm clock with dawn ramp core
// Path: an accepted item waits in the input register, then moves to the result register.
// Throughput: one item per cycle unless the result side stalls; one input and one result register.
// Reset: rst_n clears times, selectors, alarm, lamp, brightness, valid flags and stored alarm registers.
// ----------------------------------------------------------------------------
`include "alarm_clock_with_dawn_ramp_core_defines.svh"

module alarm_clock_with_dawn_ramp_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Item channel.
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  acwdr_pkg::item_t                     item,
    // Result channel.
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output acwdr_pkg::result_t                   result,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [acwdr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acwdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------------
    // Flow control. The item sits in the input register while the state
    // update is computed, and then moves into the result register
    // together with the state write. The result register frees up whenever
    // the downstream side takes its transaction, so a new item can enter in
    // every cycle as long as the result side keeps draining.
    // ------------------------------------------------------------------------
    logic               in_valid_reg;
    acwdr_pkg::item_t   in_item_reg;
    logic               result_valid_reg;
    acwdr_pkg::result_t result_reg;

    logic result_free;
    logic advance;
    logic item_take;

    assign result_free = !result_valid_reg || !result_stall;
    assign advance     = in_valid_reg && result_free;
    assign item_stall  = in_valid_reg && !result_free;
    assign item_take   = item_valid && !item_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The configuration registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // Architectural state.
    // ------------------------------------------------------------------------
    logic [4:0] stored_hour_reg;
    logic [5:0] stored_minute_reg;
    logic [4:0] hour_now_reg,   hour_now_next;
    logic [5:0] minute_now_reg, minute_now_next;
    logic [4:0] wake_hour_reg,  wake_hour_next;
    logic [5:0] wake_minute_reg, wake_minute_next;
    logic       clock_sel_reg,  clock_sel_next;
    logic       alarm_sel_reg,  alarm_sel_next;
    logic       ringing_reg,    ringing_next;
    logic       lamp_reg,       lamp_next;
    logic [7:0] level_reg,      level_next;
    logic [1:0] commit_next;

    acwdr_pkg::result_t result_next;

    // Scratch values for the minute tick and the field editor.
    logic [6:0] tick_minute;
    logic [5:0] edit_value;

    // ------------------------------------------------------------------------
    // Item evaluation. First the item's own action on the times and edit
    // selectors, then the alarm logic on the updated times: an active alarm
    // handles dismissal and ramp ticks, an idle alarm starts on a time match.
    // ------------------------------------------------------------------------
    always_comb
    begin
        hour_now_next    = hour_now_reg;
        minute_now_next  = minute_now_reg;
        wake_hour_next   = wake_hour_reg;
        wake_minute_next = wake_minute_reg;
        clock_sel_next   = clock_sel_reg;
        alarm_sel_next   = alarm_sel_reg;
        ringing_next     = ringing_reg;
        lamp_next        = lamp_reg;
        level_next       = level_reg;
        commit_next      = acwdr_pkg::COMMIT_NONE;
        tick_minute      = {1'b0, minute_now_reg} + 7'd1;
        edit_value       = 6'd0;

        case (in_item_reg.mode)
            acwdr_pkg::MODE_INIT:
            begin
                hour_now_next    = acwdr_pkg::load_hour(in_item_reg.rtc_hour);
                minute_now_next  = acwdr_pkg::load_minute(in_item_reg.rtc_minute);
                wake_hour_next   = acwdr_pkg::load_hour(stored_hour_reg);
                wake_minute_next = acwdr_pkg::load_minute(stored_minute_reg);
                clock_sel_next   = 1'b0;
            end
            acwdr_pkg::MODE_MINUTE_TICK:
            begin
                // Every tenth minute the clock resynchronizes to the RTC reading.
                if (acwdr_pkg::is_multiple_of_ten(tick_minute))
                begin
                    hour_now_next = acwdr_pkg::load_hour(in_item_reg.rtc_hour);
                    tick_minute   = {1'b0, acwdr_pkg::load_minute(in_item_reg.rtc_minute)};
                end
                if (tick_minute > {1'b0, acwdr_pkg::MINUTE_MAX})
                begin
                    minute_now_next = 6'd0;
                    hour_now_next   = ({1'b0, hour_now_next} < acwdr_pkg::HOUR_MAX)
                                    ? hour_now_next + 5'd1 : 5'd0;
                end
                else
                begin
                    minute_now_next = tick_minute[5:0];
                end
            end
            acwdr_pkg::MODE_SET_EVENT:
            begin
                if (in_item_reg.edit_alarm)
                begin
                    if (in_item_reg.enc_code == acwdr_pkg::ENC_PRESS)
                    begin
                        // First press selects the minute, second press commits.
                        alarm_sel_next = !alarm_sel_reg;
                        if (alarm_sel_reg)
                            commit_next = acwdr_pkg::COMMIT_ALARM;
                    end
                    else if (alarm_sel_reg)
                    begin
                        wake_minute_next = acwdr_pkg::step_field(in_item_reg.enc_code,
                            wake_minute_reg, acwdr_pkg::MINUTE_MAX,
                            acwdr_pkg::MINUTE_UP_TEN_LIMIT);
                    end
                    else
                    begin
                        edit_value = acwdr_pkg::step_field(in_item_reg.enc_code,
                            {1'b0, wake_hour_reg}, acwdr_pkg::HOUR_MAX,
                            acwdr_pkg::HOUR_UP_TEN_LIMIT);
                        wake_hour_next = edit_value[4:0];
                    end
                end
                else
                begin
                    if (in_item_reg.enc_code == acwdr_pkg::ENC_PRESS)
                    begin
                        clock_sel_next = !clock_sel_reg;
                        if (clock_sel_reg)
                            commit_next = acwdr_pkg::COMMIT_CLOCK;
                    end
                    else if (clock_sel_reg)
                    begin
                        minute_now_next = acwdr_pkg::step_field(in_item_reg.enc_code,
                            minute_now_reg, acwdr_pkg::MINUTE_MAX,
                            acwdr_pkg::MINUTE_UP_TEN_LIMIT);
                    end
                    else
                    begin
                        edit_value = acwdr_pkg::step_field(in_item_reg.enc_code,
                            {1'b0, hour_now_reg}, acwdr_pkg::HOUR_MAX,
                            acwdr_pkg::HOUR_UP_TEN_LIMIT);
                        hour_now_next = edit_value[4:0];
                    end
                end
            end
            default:
            begin
                // Ramp ticks, running events and unused modes only reach the
                // alarm logic below.
            end
        endcase

        if (ringing_reg)
        begin
            if (in_item_reg.mode == acwdr_pkg::MODE_RUN_EVENT &&
                in_item_reg.enc_code == acwdr_pkg::ENC_PRESS)
            begin
                // Dismissal: the lamp goes dark but the brightness is kept.
                lamp_next    = 1'b0;
                ringing_next = 1'b0;
            end
            if (in_item_reg.mode == acwdr_pkg::MODE_RAMP_TICK &&
                level_reg < acwdr_pkg::MAX_BRIGHTNESS)
            begin
                level_next = level_reg + 8'd1;
            end
        end
        else if (hour_now_next == wake_hour_next && minute_now_next == wake_minute_next)
        begin
            // Alarm start: the dawn ramp begins from dark.
            level_next   = 8'd0;
            lamp_next    = 1'b1;
            ringing_next = 1'b1;
        end

        result_next.clock_hour     = hour_now_next;
        result_next.clock_minute   = minute_now_next;
        result_next.alarm_hour     = wake_hour_next;
        result_next.alarm_minute   = wake_minute_next;
        result_next.editing_minute = in_item_reg.edit_alarm ? alarm_sel_next : clock_sel_next;
        result_next.alarm_on       = ringing_next;
        result_next.lamp_lit       = lamp_next;
        result_next.brightness     = level_next;
        result_next.commit         = commit_next;
    end

    // ------------------------------------------------------------------------
    // Control and state registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            stored_hour_reg   <= 5'd0;
            stored_minute_reg <= 6'd0;
            hour_now_reg      <= 5'd0;
            minute_now_reg    <= 6'd0;
            wake_hour_reg     <= 5'd0;
            wake_minute_reg   <= 6'd0;
            clock_sel_reg     <= 1'b0;
            alarm_sel_reg     <= 1'b0;
            ringing_reg       <= 1'b0;
            lamp_reg          <= 1'b0;
            level_reg         <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    acwdr_pkg::REG_STORED_ALARM_HOUR:   stored_hour_reg   <= cfg_data[4:0];
                    acwdr_pkg::REG_STORED_ALARM_MINUTE: stored_minute_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (item_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            if (advance)
            begin
                hour_now_reg    <= hour_now_next;
                minute_now_reg  <= minute_now_next;
                wake_hour_reg   <= wake_hour_next;
                wake_minute_reg <= wake_minute_next;
                clock_sel_reg   <= clock_sel_next;
                alarm_sel_reg   <= alarm_sel_next;
                ringing_reg     <= ringing_next;
                lamp_reg        <= lamp_next;
                level_reg       <= level_next;
            end
        end
    end

    // Payload registers: written on their transactions, no reset needed.
    always_ff @(posedge clk)
    begin
        if (item_take)
            in_item_reg <= item;
        if (advance)
            result_reg <= result_next;
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    logic times_legal;
    logic advance_not_set;

    assign times_legal = {1'b0, hour_now_reg} <= acwdr_pkg::HOUR_MAX &&
                         minute_now_reg <= acwdr_pkg::MINUTE_MAX &&
                         {1'b0, wake_hour_reg} <= acwdr_pkg::HOUR_MAX &&
                         wake_minute_reg <= acwdr_pkg::MINUTE_MAX;
    assign advance_not_set = advance && in_item_reg.mode != acwdr_pkg::MODE_SET_EVENT;

    // The lamp is lit exactly while the alarm is active.
    `ACWDR_ASSERT_ALWAYS(a_lamp_follows_alarm, lamp_reg == ringing_reg)
    // Held times never leave their legal ranges.
    `ACWDR_ASSERT_ALWAYS(a_time_in_range, times_legal)
    // Only setting events can request a commit.
    `ACWDR_ASSERT_NEXT(a_commit_only_on_set, advance_not_set, result_reg.commit == acwdr_pkg::COMMIT_NONE)
    // An input item held back by a full result side is not lost.
    `ACWDR_ASSERT_NEXT(a_stalled_item_kept, in_valid_reg && !advance, in_valid_reg)

endmodule

// ----- dv/acwdr_clock_watch.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock with dawn ramp: result watcher
// Follows the item, result and register channels of the core, keeps its own
// copy of the clock, alarm and lamp state, and compares each result
// transaction field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module acwdr_clock_watch (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  logic                                 item_stall,
    input  acwdr_pkg::item_t                     item,
    input  logic                                 result_valid,
    input  logic                                 result_stall,
    input  acwdr_pkg::result_t                   result,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [acwdr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acwdr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                   errors,
    output int                                   pending
);

    localparam logic [5:0] LAST_HOUR       = 6'd23;
    localparam logic [5:0] LAST_MINUTE     = 6'd59;
    localparam logic [5:0] HOUR_TEN_CEIL   = 6'd14;
    localparam logic [5:0] MINUTE_TEN_CEIL = 6'd50;
    localparam logic [5:0] TEN_STEP        = 6'd10;
    localparam logic [7:0] FULL_LEVEL      = 8'd255;

    // Model of the core state.
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [4:0] wake_hour;
    logic [5:0] wake_minute;
    logic       clock_on_minute;
    logic       alarm_on_minute;
    logic       ringing;
    logic       lamp;
    logic [7:0] level;
    logic [4:0] saved_hour;
    logic [5:0] saved_minute;

    acwdr_pkg::result_t expected_q[$];

    function automatic logic [4:0] fit_hour(input logic [4:0] value);
        return (value > LAST_HOUR[4:0]) ? 5'd0 : value;
    endfunction

    function automatic logic [5:0] fit_minute(input logic [5:0] value);
        return (value > LAST_MINUTE) ? 6'd0 : value;
    endfunction

    task automatic report_fault(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_fault($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // One encoder code on the hour or minute field picked by the selector.
    task automatic turn_encoder(input logic [2:0] code, inout logic [4:0] hr,
                                inout logic [5:0] mn, inout logic on_minute,
                                output logic committed);
        logic [5:0] val;
        logic [5:0] top;
        logic [5:0] ceil_ten;
        logic       was_minute;
        was_minute = on_minute;
        val        = was_minute ? mn : {1'b0, hr};
        top        = was_minute ? LAST_MINUTE : LAST_HOUR;
        ceil_ten   = was_minute ? MINUTE_TEN_CEIL : HOUR_TEN_CEIL;
        committed  = 1'b0;
        case (code)
            acwdr_pkg::ENC_DOWN:     val = (val != 6'd0 && val <= top) ? val - 6'd1 : top;
            acwdr_pkg::ENC_UP:       val = (val < top) ? val + 6'd1 : 6'd0;
            acwdr_pkg::ENC_DOWN_TEN: if (val >= TEN_STEP) val = val - TEN_STEP;
            acwdr_pkg::ENC_UP_TEN:   if (val < ceil_ten) val = val + TEN_STEP;
            acwdr_pkg::ENC_PRESS:
            begin
                committed = was_minute;
                on_minute = !was_minute;
            end
            default: ;
        endcase
        if (was_minute)
            mn = val;
        else
            hr = val[4:0];
    endtask

    task automatic predict_clock(input acwdr_pkg::item_t it,
                                 output acwdr_pkg::result_t res);
        logic [6:0] minute_count;
        logic       committed;
        logic       was_ringing;
        res         = '0;
        res.commit  = acwdr_pkg::COMMIT_NONE;
        was_ringing = ringing;
        case (it.mode)
            acwdr_pkg::MODE_INIT:
            begin
                now_hour        = fit_hour(it.rtc_hour);
                now_minute      = fit_minute(it.rtc_minute);
                wake_hour       = fit_hour(saved_hour);
                wake_minute     = fit_minute(saved_minute);
                clock_on_minute = 1'b0;
            end
            acwdr_pkg::MODE_MINUTE_TICK:
            begin
                minute_count = {1'b0, now_minute} + 7'd1;
                if (minute_count % 7'd10 == 7'd0)
                begin
                    now_hour     = fit_hour(it.rtc_hour);
                    minute_count = {1'b0, fit_minute(it.rtc_minute)};
                end
                if (minute_count > {1'b0, LAST_MINUTE})
                begin
                    minute_count = 7'd0;
                    now_hour = (now_hour < LAST_HOUR[4:0]) ? now_hour + 5'd1 : 5'd0;
                end
                now_minute = minute_count[5:0];
            end
            acwdr_pkg::MODE_SET_EVENT:
            begin
                if (it.edit_alarm)
                begin
                    turn_encoder(it.enc_code, wake_hour, wake_minute, alarm_on_minute,
                                 committed);
                    if (committed)
                        res.commit = acwdr_pkg::COMMIT_ALARM;
                end
                else
                begin
                    turn_encoder(it.enc_code, now_hour, now_minute, clock_on_minute,
                                 committed);
                    if (committed)
                        res.commit = acwdr_pkg::COMMIT_CLOCK;
                end
            end
            default: ;
        endcase

        if (was_ringing)
        begin
            if (it.mode == acwdr_pkg::MODE_RUN_EVENT && it.enc_code == acwdr_pkg::ENC_PRESS)
            begin
                lamp    = 1'b0;
                ringing = 1'b0;
            end
            if (it.mode == acwdr_pkg::MODE_RAMP_TICK && level < FULL_LEVEL)
                level = level + 8'd1;
        end
        else if (now_hour == wake_hour && now_minute == wake_minute)
        begin
            level   = 8'd0;
            lamp    = 1'b1;
            ringing = 1'b1;
        end

        res.clock_hour     = now_hour;
        res.clock_minute   = now_minute;
        res.alarm_hour     = wake_hour;
        res.alarm_minute   = wake_minute;
        res.editing_minute = it.edit_alarm ? alarm_on_minute : clock_on_minute;
        res.alarm_on       = ringing;
        res.lamp_lit       = lamp;
        res.brightness     = level;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        acwdr_pkg::result_t want;
        if (!rst_n)
        begin
            now_hour        = '0;
            now_minute      = '0;
            wake_hour       = '0;
            wake_minute     = '0;
            clock_on_minute = 1'b0;
            alarm_on_minute = 1'b0;
            ringing         = 1'b0;
            lamp            = 1'b0;
            level           = '0;
            saved_hour      = '0;
            saved_minute    = '0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    acwdr_pkg::REG_STORED_ALARM_HOUR:   saved_hour   = cfg_data[4:0];
                    acwdr_pkg::REG_STORED_ALARM_MINUTE: saved_minute = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                    report_fault("result transaction with nothing expected");
                else
                begin
                    want = expected_q.pop_front();
                    check_field("clock_hour", 32'(result.clock_hour),
                                32'(want.clock_hour));
                    check_field("clock_minute", 32'(result.clock_minute),
                                32'(want.clock_minute));
                    check_field("alarm_hour", 32'(result.alarm_hour),
                                32'(want.alarm_hour));
                    check_field("alarm_minute", 32'(result.alarm_minute),
                                32'(want.alarm_minute));
                    check_field("editing_minute", 32'(result.editing_minute),
                                32'(want.editing_minute));
                    check_field("alarm_on", 32'(result.alarm_on), 32'(want.alarm_on));
                    check_field("lamp_lit", 32'(result.lamp_lit), 32'(want.lamp_lit));
                    check_field("brightness", 32'(result.brightness),
                                32'(want.brightness));
                    check_field("commit", 32'(result.commit), 32'(want.commit));
                end
            end
            if (item_valid && !item_stall)
            begin
                predict_clock(item, want);
                expected_q.push_back(want);
            end
        end
        pending = expected_q.size();
    end

endmodule

// ----- dv/tb_alarm_clock_with_dawn_ramp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock with dawn ramp core: testbench
// Drives a short directed sequence and then random bursts (alarm rings with
// dawn ramps, minute countdowns to the alarm, setting sessions, noise) over
// several stored alarm settings, with random idling on both channels. The
// watcher beside the core predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_alarm_clock_with_dawn_ramp_core;

    localparam int IDLE_PCT   = 14;
    localparam int IDLE_LIMIT = 4000;
    localparam int ITEM_GOAL  = 1000;

    // Modes and encoder codes the core gives no meaning to.
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam logic [2:0] ENC_NONE         = 3'd0;
    localparam logic [2:0] ENC_SPARE_MID    = 3'd4;
    localparam logic [2:0] ENC_SPARE_TOP    = 3'd7;

    logic                              clk;
    logic                              rst_n        = 1'b0;
    logic                              item_valid   = 1'b0;
    logic                              item_stall;
    acwdr_pkg::item_t                  item         = '0;
    logic                              result_valid;
    logic                              result_stall = 1'b0;
    acwdr_pkg::result_t                result;
    logic                              cfg_valid    = 1'b0;
    logic                              cfg_ready;
    logic [acwdr_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [acwdr_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    int   fault_count;
    int   open_count;
    int   sent  = 0;
    int   stuck = 0;
    logic calm  = 1'b0;

    // Alarm time that an initialize transaction loads from the stored values.
    // The stimulus uses it to steer the clock onto the alarm.
    logic [4:0] wake_h;
    logic [5:0] wake_m;

    alarm_clock_with_dawn_ramp_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    acwdr_clock_watch watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (fault_count),
        .pending      (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver stalls at random, except during the calm stretch. The
    // decision is made at the falling edge so it is stable at the next rise.
    always @(negedge clk)
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    // Any accepted transaction on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
    end

    initial
    begin
        wait (rst_n);
        while (stuck < IDLE_LIMIT)
            @(posedge clk);
        $display("tb_alarm_clock_with_dawn_ramp_core: done, errors");
        $finish;
    end

    function automatic acwdr_pkg::item_t make_item(input logic [2:0] mode,
                                                   input logic [2:0] code,
                                                   input logic tgt,
                                                   input logic [4:0] hr,
                                                   input logic [5:0] mn);
        acwdr_pkg::item_t it;
        it.mode       = mode;
        it.enc_code   = code;
        it.edit_alarm = tgt;
        it.rtc_hour   = hr;
        it.rtc_minute = mn;
        return it;
    endfunction

    // Any item at all. Real-time-clock readings are mostly in range, but the
    // whole field width is reached, and every mode including the unused ones.
    function automatic acwdr_pkg::item_t noise_item();
        acwdr_pkg::item_t it;
        int               pick;
        it.enc_code   = 3'($urandom_range(7));
        it.edit_alarm = 1'($urandom_range(1));
        it.rtc_hour   = ($urandom_range(99) < 80) ? 5'($urandom_range(23))
                                                  : 5'($urandom_range(31));
        it.rtc_minute = ($urandom_range(99) < 80) ? 6'($urandom_range(59))
                                                  : 6'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 8)
            it.mode = acwdr_pkg::MODE_INIT;
        else if (pick < 30)
            it.mode = acwdr_pkg::MODE_MINUTE_TICK;
        else if (pick < 50)
            it.mode = acwdr_pkg::MODE_RAMP_TICK;
        else if (pick < 80)
            it.mode = acwdr_pkg::MODE_SET_EVENT;
        else if (pick < 94)
            it.mode = acwdr_pkg::MODE_RUN_EVENT;
        else
            it.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        return it;
    endfunction

    function automatic logic [2:0] step_code();
        logic [2:0] code;
        case ($urandom_range(3))
            0:       code = acwdr_pkg::ENC_DOWN;
            1:       code = acwdr_pkg::ENC_UP;
            2:       code = acwdr_pkg::ENC_DOWN_TEN;
            default: code = acwdr_pkg::ENC_UP_TEN;
        endcase
        return code;
    endfunction

    // Presents one item and returns at the falling edge after its acceptance,
    // with valid still high so a following item can go out back to back.
    task automatic send_item(input acwdr_pkg::item_t it);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic settle();
        item_valid <= 1'b0;
        while (open_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes both stored alarm registers in two back-to-back transactions.
    task automatic load_alarm_regs(input logic [5:0] hr_data, input logic [5:0] mn_data);
        cfg_valid <= 1'b1;
        cfg_index <= acwdr_pkg::REG_STORED_ALARM_HOUR;
        cfg_data  <= hr_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_index <= acwdr_pkg::REG_STORED_ALARM_MINUTE;
        cfg_data  <= mn_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        // Only five bits of the hour are kept; out-of-range values load as zero.
        wake_h = (hr_data[4:0] > 5'd23) ? 5'd0 : hr_data[4:0];
        wake_m = (mn_data > 6'd59) ? 6'd0 : mn_data;
    endtask

    // Dismisses any ringing alarm, then loads the clock onto the alarm time so
    // that it rings, ramps the lamp for a while and at random dismisses it.
    task automatic ring_burst(input int ramps);
        send_item(make_item(acwdr_pkg::MODE_RUN_EVENT, acwdr_pkg::ENC_PRESS, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_INIT, ENC_NONE, 1'b0, wake_h, wake_m));
        for (int i = 0; i < ramps; i++)
        begin
            if ($urandom_range(99) < 85)
                send_item(make_item(acwdr_pkg::MODE_RAMP_TICK, 3'($urandom_range(7)),
                                    1'($urandom_range(1)), 5'($urandom_range(31)),
                                    6'($urandom_range(63))));
            else
                send_item(noise_item());
        end
        if ($urandom_range(1))
            send_item(make_item(acwdr_pkg::MODE_RUN_EVENT, acwdr_pkg::ENC_PRESS,
                                1'($urandom_range(1)), 5'd0, 6'd0));
        if ($urandom_range(1))
            send_item(noise_item());
    endtask

    // Sets the clock a few minutes short of the alarm and ticks up to it. The
    // readings carried by each tick follow the count, so a resync on a
    // multiple of ten lands on the same time.
    task automatic approach_burst();
        int         steps;
        logic [5:0] start;
        steps = $urandom_range(1, 12);
        if (steps > int'(wake_m))
            steps = int'(wake_m);
        start = wake_m - 6'(steps);
        send_item(make_item(acwdr_pkg::MODE_RUN_EVENT, acwdr_pkg::ENC_PRESS, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_INIT, ENC_NONE, 1'b0, wake_h, start));
        for (int i = 1; i <= steps; i++)
            send_item(make_item(acwdr_pkg::MODE_MINUTE_TICK, ENC_NONE, 1'b0, wake_h,
                                start + 6'(i)));
        repeat ($urandom_range(0, 4))
            send_item(make_item(acwdr_pkg::MODE_RAMP_TICK, ENC_NONE, 1'b0, 5'd0, 6'd0));
    endtask

    // A setting session: steps, a press to switch field or commit, more steps,
    // and a second press.
    task automatic setting_burst();
        logic tgt;
        tgt = 1'($urandom_range(1));
        repeat ($urandom_range(0, 5))
            send_item(make_item(acwdr_pkg::MODE_SET_EVENT, step_code(), tgt,
                                5'($urandom_range(31)), 6'($urandom_range(63))));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_PRESS, tgt,
                            5'd0, 6'd0));
        repeat ($urandom_range(0, 5))
            send_item(make_item(acwdr_pkg::MODE_SET_EVENT, step_code(), tgt,
                                5'($urandom_range(31)), 6'($urandom_range(63))));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_PRESS, tgt,
                            5'd0, 6'd0));
    endtask

    initial
    begin
        int goal;
        int pick;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part.
        load_alarm_regs(6'd7, 6'd45);
        // Initialize at zero, with out-of-range readings, and at the last minute
        // of the day.
        send_item(make_item(acwdr_pkg::MODE_INIT, ENC_NONE, 1'b0, 5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_INIT, ENC_NONE, 1'b0, 5'd31, 6'd63));
        send_item(make_item(acwdr_pkg::MODE_INIT, ENC_NONE, 1'b0, 5'd23, 6'd59));
        // The first tick rolls onto a multiple of ten and resyncs; the second
        // only advances.
        send_item(make_item(acwdr_pkg::MODE_MINUTE_TICK, ENC_NONE, 1'b0, 5'd5, 6'd10));
        send_item(make_item(acwdr_pkg::MODE_MINUTE_TICK, ENC_NONE, 1'b0, 5'd0, 6'd0));
        // Every code on the clock hour, the unused ones among them, then a
        // press to the minute, a step, and a commit.
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_DOWN, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_UP, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_DOWN_TEN, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_UP_TEN, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, ENC_NONE, 1'b0, 5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, ENC_SPARE_MID, 1'b0, 5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, ENC_SPARE_TOP, 1'b0, 5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_PRESS, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_UP, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_PRESS, 1'b0,
                            5'd0, 6'd0));
        // Alarm minute up by ten and an alarm commit.
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_PRESS, 1'b1,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_UP_TEN, 1'b1,
                            5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_SET_EVENT, acwdr_pkg::ENC_PRESS, 1'b1,
                            5'd0, 6'd0));
        // A press while running with no alarm, and the unused modes.
        send_item(make_item(acwdr_pkg::MODE_RUN_EVENT, acwdr_pkg::ENC_PRESS, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(MODE_SPARE_FIRST, ENC_NONE, 1'b0, 5'd0, 6'd0));
        send_item(make_item(MODE_SPARE_LAST, ENC_NONE, 1'b1, 5'd0, 6'd0));
        // Ring, ramp once, dismiss, and restart on the next item since the
        // times still match.
        send_item(make_item(acwdr_pkg::MODE_INIT, ENC_NONE, 1'b0, 5'd7, 6'd45));
        send_item(make_item(acwdr_pkg::MODE_RAMP_TICK, ENC_NONE, 1'b0, 5'd0, 6'd0));
        send_item(make_item(acwdr_pkg::MODE_RUN_EVENT, acwdr_pkg::ENC_PRESS, 1'b0,
                            5'd0, 6'd0));
        send_item(make_item(MODE_SPARE_MID, ENC_NONE, 1'b0, 5'd0, 6'd0));
        settle();

        // Random part, in phases with different stored alarm settings: the
        // low extreme, the high legal extreme, all ones, just out of range,
        // and random values over the full register width, then random legal ones.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       load_alarm_regs(6'd0, 6'd0);
                1:       load_alarm_regs(6'd23, 6'd59);
                2:       load_alarm_regs(6'd63, 6'd63);
                3:       load_alarm_regs(6'd24, 6'd60);
                4:       load_alarm_regs(6'($urandom_range(63)), 6'($urandom_range(63)));
                default: load_alarm_regs(6'($urandom_range(23)), 6'($urandom_range(59)));
            endcase
            goal = 25 + (phase + 1) * (ITEM_GOAL - 25) / 6;
            // One long ring burst ramps the brightness up toward its maximum.
            if (phase == 1)
                ring_burst(262);
            while (sent < goal)
            begin
                // Phase two opens with a stretch without any idling.
                calm <= (phase == 2) && (sent < goal - 60);
                pick = $urandom_range(99);
                if (pick < 25)
                    ring_burst($urandom_range(1, 12));
                else if (pick < 40)
                    approach_burst();
                else if (pick < 60)
                    setting_burst();
                else
                    repeat ($urandom_range(3, 10)) send_item(noise_item());
            end
            calm <= 1'b0;
            settle();
        end

        if (fault_count == 0 && open_count == 0)
            $display("tb_alarm_clock_with_dawn_ramp_core: done, clean");
        else
            $display("tb_alarm_clock_with_dawn_ramp_core: done, errors");
        $finish;
    end

endmodule

// ----- alarm_clock_with_dawn_ramp_core.f -----
+incdir+hdl
hdl/acwdr_pkg.sv
hdl/alarm_clock_with_dawn_ramp_core.sv
dv/acwdr_clock_watch.sv
dv/tb_alarm_clock_with_dawn_ramp_core.sv
